// File: rtl/nmea_command_framer_top_macros.svh
// Assertion macros used by the checker module of the sentence framer.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef NMEA_COMMAND_FRAMER_TOP_MACROS_SVH
`define NMEA_COMMAND_FRAMER_TOP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define NCF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer checker: assertion failed");

// The consequent holds in the cycle after the antecedent.
`define NCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer checker: assertion failed");

// The consequent is checked later than under NCF_ASSERT_NEXT, after a further delay.
`define NCF_ASSERT_LATER(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
        else $error("framer checker: assertion failed");

`endif

// File: rtl/ncf_pkg.sv
package ncf_pkg;

    // Characters of the sentence frame.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_K      = 8'h4B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Checksum of the prefix characters that follow the dollar sign.
    localparam logic [7:0] PREFIX_CSUM = CH_P ^ CH_M ^ CH_T ^ CH_K;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       has_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       sentence_end;
    } out_item_t;

    // One classified item as it waits between the front and the back.
    typedef struct packed {
        logic       prefix;
        logic       has_byte;
        logic       last_byte;
        logic [7:0] body_byte;
        logic [7:0] csum;
    } cmd_t;

    // Upper-case hexadecimal character for one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
    endfunction

endpackage

// File: rtl/ncf_front.sv
module ncf_front
    import ncf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    output logic     cmd_valid,
    output cmd_t     cmd
);

    logic       open_reg;
    logic       open_next;
    logic [7:0] csum_reg;
    logic [7:0] csum_next;
    logic [7:0] csum_base;
    logic [7:0] csum_new;

    // A fresh sentence starts its checksum from the prefix characters.
    assign csum_base = open_reg ? csum_reg : PREFIX_CSUM;
    assign csum_new  = item.has_byte ? (csum_base ^ item.body_byte) : csum_base;

    always_comb
    begin
        cmd.prefix    = !open_reg;
        cmd.has_byte  = item.has_byte;
        cmd.last_byte = item.last_byte;
        cmd.body_byte = item.body_byte;
        cmd.csum      = csum_new;
        // An empty item inside an open sentence produces nothing at all.
        cmd_valid = accept && (!open_reg || item.has_byte || item.last_byte);
    end

    always_comb
    begin
        open_next = open_reg;
        csum_next = csum_reg;
        if (accept)
        begin
            open_next = !item.last_byte;
            csum_next = item.last_byte ? 8'h00 : csum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            csum_reg <= 8'h00;
        end
        else
        begin
            open_reg <= open_next;
            csum_reg <= csum_next;
        end
    end

endmodule

// File: rtl/ncf_cmd_fifo.sv
module ncf_cmd_fifo
    import ncf_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic full,
    output logic empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/ncf_back.sv
module ncf_back
    import ncf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  cmd_t      head,
    output logic      head_done,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    typedef enum logic [3:0] {
        PH_DOLLAR,
        PH_P,
        PH_M,
        PH_T,
        PH_K,
        PH_BODY,
        PH_STAR,
        PH_HI,
        PH_LO,
        PH_CR,
        PH_LF
    } phase_t;

    phase_t     phase_reg;
    phase_t     first_phase;
    phase_t     cur_phase;
    phase_t     nxt_phase;
    logic       busy_reg;
    logic       last_step;
    logic       advance;
    logic [7:0] char_now;
    out_item_t  out_reg;
    logic       out_valid_reg;

    assign first_phase = head.prefix ? PH_DOLLAR : (head.has_byte ? PH_BODY : PH_STAR);
    assign cur_phase   = busy_reg ? phase_reg : first_phase;
    assign advance     = head_valid && (!out_valid_reg || pop);
    assign head_done   = advance && last_step;
    assign empty       = !out_valid_reg;
    assign result      = out_reg;

    always_comb
    begin
        char_now  = CH_LF;
        nxt_phase = PH_DOLLAR;
        last_step = 1'b1;
        case (cur_phase)
            PH_DOLLAR:
            begin
                char_now  = CH_DOLLAR;
                nxt_phase = PH_P;
                last_step = 1'b0;
            end
            PH_P:
            begin
                char_now  = CH_P;
                nxt_phase = PH_M;
                last_step = 1'b0;
            end
            PH_M:
            begin
                char_now  = CH_M;
                nxt_phase = PH_T;
                last_step = 1'b0;
            end
            PH_T:
            begin
                char_now  = CH_T;
                nxt_phase = PH_K;
                last_step = 1'b0;
            end
            PH_K:
            begin
                char_now  = CH_K;
                nxt_phase = head.has_byte ? PH_BODY : PH_STAR;
                last_step = !head.has_byte && !head.last_byte;
            end
            PH_BODY:
            begin
                char_now  = head.body_byte;
                nxt_phase = PH_STAR;
                last_step = !head.last_byte;
            end
            PH_STAR:
            begin
                char_now  = CH_STAR;
                nxt_phase = PH_HI;
                last_step = 1'b0;
            end
            PH_HI:
            begin
                char_now  = hex_digit(head.csum[7:4]);
                nxt_phase = PH_LO;
                last_step = 1'b0;
            end
            PH_LO:
            begin
                char_now  = hex_digit(head.csum[3:0]);
                nxt_phase = PH_CR;
                last_step = 1'b0;
            end
            PH_CR:
            begin
                char_now  = CH_CR;
                nxt_phase = PH_LF;
                last_step = 1'b0;
            end
            PH_LF:
            begin
                char_now  = CH_LF;
                nxt_phase = PH_DOLLAR;
                last_step = 1'b1;
            end
            default:
            begin
                char_now  = CH_LF;
                nxt_phase = PH_DOLLAR;
                last_step = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DOLLAR;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (advance)
        begin
            out_reg.out_char     <= char_now;
            out_reg.sentence_end <= (cur_phase == PH_LF);
            out_valid_reg        <= 1'b1;
            busy_reg             <= !last_step;
            phase_reg            <= nxt_phase;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

// File: rtl/nmea_command_framer_top.sv
// Accepted items enter the command queue and reach the result ports through the result register.
// Throughput: one item per cycle while items carry only a body byte and no result waits; the
// back sequencer emits one character per cycle unless a result waits, so the five-character
// prefix and suffix bursts drain at that rate and full rises only once the command queue of
// QUEUE_DEPTH entries has filled up. Reset: rst_n is asynchronous and active low; it closes
// any open sentence, clears the checksum and empties the command queue and result register.
module nmea_command_framer_top
    import ncf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    // The front half classifies every accepted item: it decides whether the item opens a
    // sentence (and so needs the prefix), keeps the running checksum, and hands the back
    // half the running checksum together with the body byte and the closing flag. An empty
    // item inside an open sentence leaves nothing in the queue.
    logic front_accept;
    logic cmd_valid;
    cmd_t cmd;

    // Between the halves sits a short queue of classified items so that a long prefix or
    // suffix burst in the back does not stall the input until the queue runs full.
    cmd_t head;
    logic queue_empty;
    logic head_done;

    assign front_accept = push && !full;

    ncf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (front_accept),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    ncf_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_data (cmd),
        .rd_en   (head_done),
        .rd_data (head),
        .full    (full),
        .empty   (queue_empty)
    );

    // The back half walks each queued item through its characters into a result register, one
    // per cycle while it may move on. It moves on whenever the register is free or is being
    // popped, so a waiting result holds up the front half only once the queue has run full.
    ncf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!queue_empty),
        .head       (head),
        .head_done  (head_done),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

// File: rtl/ncf_checker.sv
`include "nmea_command_framer_top_macros.svh"

module ncf_checker
    import ncf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      push,
    input logic      full,
    input in_item_t  item,
    input logic      pop,
    input logic      empty,
    input out_item_t result
);

    logic end_taken;

    // The closing line feed of a sentence leaves the block at this edge.
    assign end_taken = pop && !empty && result.sentence_end;

    // A result that is not taken stays put.
    `NCF_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(result))

    // Only the closing line feed carries the end flag.
    `NCF_ASSERT_SAME(a_end_is_lf, !empty && result.sentence_end, result.out_char == CH_LF)

    // Once a sentence has been taken, the next result opens a new one.
    `NCF_ASSERT_SAME(a_dollar_after_end, $past(end_taken) && !empty, result.out_char == CH_DOLLAR)

    // Once an accepted item that carries a byte has passed the command queue and the result register, a result waits.
    `NCF_ASSERT_LATER(a_byte_latency, push && !full && item.has_byte, !empty)

endmodule

bind nmea_command_framer_top ncf_checker u_checker (.*);

// File: test/nmea_command_framer_top_tb.sv
module nmea_command_framer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ncf_pkg::*;

    // Cycles without any accepted item on either side before the run is abandoned.
    // The slowest correct stretch is the deliberate receiver hold-off of
    // HOLDOFF_CYCLES, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 100;
    localparam int SETTLE_CYCLES  = 10;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  item = '0;
    logic      pop = 1'b0;
    logic      empty;
    out_item_t result;

    // Characters still owed by the block, oldest first.
    out_item_t expected_chars[$];

    // Mirror of the framer's own state.
    logic       sentence_open = 1'b0;
    logic [7:0] frame_csum = 8'h00;

    int fail_count = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    // Idle rates in per cent, changed by the test sequence between phases.
    int sender_idle_pct = 0;
    int recv_idle_pct = 0;

    // Set by the test sequence; the receiver process takes it over and counts it down.
    int holdoff_request = 0;

    nmea_command_framer_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Upper-case hexadecimal character for one nibble of the checksum.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return 8'h30 + {4'h0, nib};
        end
        return 8'h41 + {4'h0, nib} - 8'd10;
    endfunction

    task automatic owe_char(input logic [7:0] ch, input logic last_char);
        out_item_t c;
        c.out_char = ch;
        c.sentence_end = last_char;
        expected_chars.push_back(c);
    endtask

    // Works out the characters that one accepted item causes. A closed sentence is
    // opened with the prefix first; the checksum covers everything after the dollar
    // sign, and a closing item appends the star, two hex digits, CR and LF.
    task automatic predict_frame_chars(input in_item_t it);
        if (!sentence_open)
        begin
            owe_char(CH_DOLLAR, 1'b0);
            owe_char(CH_P, 1'b0);
            owe_char(CH_M, 1'b0);
            owe_char(CH_T, 1'b0);
            owe_char(CH_K, 1'b0);
            frame_csum = CH_P ^ CH_M ^ CH_T ^ CH_K;
            sentence_open = 1'b1;
        end
        if (it.has_byte)
        begin
            owe_char(it.body_byte, 1'b0);
            frame_csum = frame_csum ^ it.body_byte;
        end
        if (it.last_byte)
        begin
            owe_char(CH_STAR, 1'b0);
            owe_char(hex_char(frame_csum[7:4]), 1'b0);
            owe_char(hex_char(frame_csum[3:0]), 1'b0);
            owe_char(CH_CR, 1'b0);
            owe_char(CH_LF, 1'b1);
            sentence_open = 1'b0;
            frame_csum = 8'h00;
        end
    endtask

    // Compares one character leaving the block with the oldest one owed. Only the
    // first ten problems are described; the rest are merely counted.
    task automatic check_char(input out_item_t got);
        out_item_t want;
        if (expected_chars.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("Unexpected character %h (sentence_end %b) at %0t",
                         got.out_char, got.sentence_end, $realtime);
            end
        end
        else
        begin
            want = expected_chars.pop_front();
            if (got.out_char !== want.out_char || got.sentence_end !== want.sentence_end)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("Mismatch at %0t: expected char %h end %b, got char %h end %b",
                             $realtime, want.out_char, want.sentence_end,
                             got.out_char, got.sentence_end);
                end
            end
        end
    endtask

    // Both sides are observed in one process at the rising edge. The result is
    // checked before the item of the same edge is predicted, so that a character
    // appearing too early can never be matched against its own expectation.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            check_char(result);
        end
        if (rst_n && push && !full)
        begin
            predict_frame_chars(item);
        end
        if (rst_n && ((pop && !empty) || (push && !full)))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("nmea_command_framer_top_tb failed");
        $finish;
    end

    // Receiver: pops at random according to recv_idle_pct, unless a hold-off is
    // in progress, during which it refuses every character.
    always @(negedge clk)
    begin
        int holdoff_left;
        if (holdoff_request > 0)
        begin
            holdoff_left = holdoff_request;
            holdoff_request = 0;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one item, after a random gap when the sender is meant to idle, and
    // returns at the rising edge that accepts it. Push is left high so that the
    // next item can follow without a bubble.
    task automatic send_item(input logic [7:0] body, input logic has, input logic last);
        in_item_t next_item;
        next_item.body_byte = body;
        next_item.has_byte = has;
        next_item.last_byte = last;
        @(negedge clk);
        // Each cycle is left idle with the sender's idle rate.
        while ($urandom_range(99) < sender_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= next_item;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Stops offering items and waits until every owed character has come out.
    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (expected_chars.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // The edges of the fields and the special cases: an empty body, a sentence of
    // one byte, an empty item on a closed and on an open sentence, zero and all-ones
    // bytes, frame delimiters inside the body, and a pause mid-sentence.
    task automatic test_special_items();
        sender_idle_pct = 29;
        recv_idle_pct = 78;
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h41, 1'b1, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(CH_DOLLAR, 1'b1, 1'b0);
        send_item(CH_STAR, 1'b1, 1'b0);
        send_item(CH_CR, 1'b1, 1'b0);
        send_item(CH_LF, 1'b1, 1'b0);
        // The open sentence must keep its checksum while the input stays quiet.
        wait_drained();
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b1);
        send_item(8'h31, 1'b1, 1'b0);
        send_item(8'hC3, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering a
    // long sentence, so the command queue fills and full has to stall the input.
    task automatic test_full_queue_stall();
        int n;
        sender_idle_pct = 0;
        recv_idle_pct = 0;
        holdoff_request = HOLDOFF_CYCLES;
        for (n = 0; n < 16; n++)
        begin
            send_item(8'($urandom_range(8'h20, 8'h7E)), 1'b1, n == 15);
        end
        wait_drained();
    endtask

    // Mostly well-formed sentences of random length and content, with some empty
    // items, raw bytes and delimiters mixed in, until the given number of items
    // has been accepted.
    task automatic test_random_sentences(input int snd_pct, input int rcv_pct,
                                         input int count);
        int start;
        int len;
        int n;
        logic [7:0] b;
        sender_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        start = items_sent;
        while (items_sent - start < count)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
            for (n = 0; n < len; n++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    // Empty item on an open sentence: the body bits are noise.
                    send_item(8'($urandom), 1'b0, 1'b0);
                end
                else
                begin
                    case ($urandom_range(9))
                        0, 1:    b = 8'($urandom);
                        2:
                        begin
                            case ($urandom_range(3))
                                0:       b = CH_DOLLAR;
                                1:       b = CH_STAR;
                                2:       b = CH_CR;
                                default: b = CH_LF;
                            endcase
                        end
                        default: b = 8'($urandom_range(8'h20, 8'h7E));
                    endcase
                    send_item(b, 1'b1, 1'b0);
                end
            end
            // The closing item may or may not carry a byte of its own.
            send_item(8'($urandom), 1'($urandom), 1'b1);
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_special_items();
        test_full_queue_stall();
        test_random_sentences(29, 78, 40);
        test_random_sentences(78, 29, 40);
        test_random_sentences(0, 0, 40);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_chars.size() != 0)
        begin
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("nmea_command_framer_top_tb passed");
        end
        else
        begin
            $display("nmea_command_framer_top_tb failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ncf_pkg.sv
rtl/ncf_front.sv
rtl/ncf_cmd_fifo.sv
rtl/ncf_back.sv
rtl/nmea_command_framer_top.sv
rtl/ncf_checker.sv
test/nmea_command_framer_top_tb.sv
